>>> hdl/brs_pkg.sv
// Shared types and constants for the bounded random rejection sampler.
package brs_pkg;

    // Field and register widths
    localparam int DATA_W    = 64;
    localparam int CNT_W     = 7;    // holds a bit count of 0..64
    localparam int CFG_IDX_W = 2;

    // Leading-one search is split into byte groups
    localparam int GRP_W = 8;
    localparam int NGRP  = DATA_W / GRP_W;
    localparam int MSB_W = $clog2(GRP_W);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LOWER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_UPPER = 2'd1;

    // How a word is handled, decided at the input
    typedef enum logic [1:0]
    {
        CLS_NORMAL,
        CLS_EMPTY,
        CLS_ERR
    } word_class_t;

    typedef struct packed
    {
        word_class_t         cls;
        logic [DATA_W-1:0]   word;
    } q_entry_t;

    // Work tokens passed from the draw engine to the output stage
    typedef enum logic [2:0]
    {
        TK_NONE,
        TK_DRAW,
        TK_END,
        TK_ERR,
        TK_EMPTY
    } tok_kind_t;

    typedef struct packed
    {
        tok_kind_t           kind;
        logic [DATA_W-1:0]   cand;
    } token_t;

    // Settings derived from the bound registers
    typedef struct packed
    {
        logic [DATA_W-1:0]   lower;
        logic [DATA_W-1:0]   span;
        logic [CNT_W-1:0]    k;
        logic                clear;
    } cfg_info_t;

    // Draw engine states
    typedef enum logic [2:0]
    {
        ST_IDLE = 3'b001,
        ST_DRAW = 3'b010,
        ST_END  = 3'b100
    } back_state_t;

endpackage

>>> hdl/brs_fifo.sv
// Short register queue between the input classifier and the draw engine.
module brs_fifo #(
    parameter int WIDTH = 66,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage, no reset
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue fill count above depth");

endmodule

>>> hdl/brs_front.sv
// Bound registers, derived draw width and input word classification.
module brs_front #(
    parameter int WORD_BITS = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [brs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [brs_pkg::DATA_W-1:0]        cfg_data,
    input  logic                              entropy_valid,
    output logic                              entropy_stall,
    input  logic [brs_pkg::DATA_W-1:0]        entropy_word,
    input  logic                              q_full,
    output logic                              push,
    output brs_pkg::q_entry_t                 push_data,
    output brs_pkg::cfg_info_t                cfg_info
);

    import brs_pkg::*;

    localparam logic [DATA_W-1:0] WORD_MASK = ~({DATA_W{1'b1}} << WORD_BITS);

    logic [DATA_W-1:0] lower_reg, upper_reg;
    logic [DATA_W-1:0] span_reg;
    logic [DATA_W-1:0] diff;
    logic              grp_nz_reg   [NGRP];
    logic              grp_nz_next  [NGRP];
    logic [MSB_W-1:0]  grp_msb_reg  [NGRP];
    logic [MSB_W-1:0]  grp_msb_next [NGRP];
    logic [CNT_W-1:0]  k_reg, k_next;
    logic              wr_bound;
    word_class_t       cls;

    assign diff     = upper_reg - lower_reg;
    assign wr_bound = cfg_write && (cfg_index == REG_LOWER || cfg_index == REG_UPPER);

    // Leading one, first step: per-byte nonzero flag and top set bit
    always_comb
    begin
        for (int g = 0; g < NGRP; g++)
        begin
            grp_nz_next[g]  = |diff[g*GRP_W +: GRP_W];
            grp_msb_next[g] = '0;
            for (int b = 0; b < GRP_W; b++)
            begin
                if (diff[g*GRP_W + b])
                begin
                    grp_msb_next[g] = MSB_W'(b);
                end
            end
        end
    end

    // Leading one, second step: highest nonzero byte gives k
    always_comb
    begin
        k_next = '0;
        for (int g = 0; g < NGRP; g++)
        begin
            if (grp_nz_reg[g])
            begin
                k_next = CNT_W'(g * GRP_W) + CNT_W'(grp_msb_reg[g]) + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lower_reg <= '0;
            upper_reg <= '0;
            span_reg  <= '0;
            k_reg     <= '0;
            for (int g = 0; g < NGRP; g++)
            begin
                grp_nz_reg[g]  <= 1'b0;
                grp_msb_reg[g] <= '0;
            end
        end
        else
        begin
            if (cfg_write && cfg_index == REG_LOWER)
            begin
                lower_reg <= cfg_data;
            end
            if (cfg_write && cfg_index == REG_UPPER)
            begin
                upper_reg <= cfg_data;
            end
            span_reg <= diff;
            k_reg    <= k_next;
            for (int g = 0; g < NGRP; g++)
            begin
                grp_nz_reg[g]  <= grp_nz_next[g];
                grp_msb_reg[g] <= grp_msb_next[g];
            end
        end
    end

    // Classify the word against the current bounds
    always_comb
    begin
        if (upper_reg < lower_reg)
        begin
            cls = CLS_ERR;
        end
        else if (upper_reg == lower_reg)
        begin
            cls = CLS_EMPTY;
        end
        else
        begin
            cls = CLS_NORMAL;
        end
    end

    assign entropy_stall  = q_full;
    assign push           = entropy_valid && !q_full;
    assign push_data.cls  = cls;
    assign push_data.word = entropy_word & WORD_MASK;

    assign cfg_info.lower = lower_reg;
    assign cfg_info.span  = span_reg;
    assign cfg_info.k     = k_reg;
    assign cfg_info.clear = wr_bound;

endmodule

>>> hdl/brs_back.sv
// Draw engine: cuts queued words into k-bit draws, one step per cycle while adv is high.
module brs_back #(
    parameter int WORD_BITS = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  brs_pkg::cfg_info_t   cfg_info,
    input  logic                 q_empty,
    input  brs_pkg::q_entry_t    q_data,
    output logic                 pop,
    input  logic                 adv,
    output brs_pkg::token_t      token
);

    import brs_pkg::*;

    localparam int REM_W = $clog2(WORD_BITS + 1);

    back_state_t       state_reg, state_next;
    logic [DATA_W-1:0] word_reg, word_next;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [DATA_W-1:0] pdraw_reg, pdraw_next;
    logic [CNT_W-1:0]  pbits_reg, pbits_next;
    token_t            tok_reg, tok_next;

    logic              stale;
    logic [CNT_W-1:0]  eff_bits;
    logic [DATA_W-1:0] eff_draw;
    logic [CNT_W-1:0]  need, avail, take;
    logic [DATA_W-1:0] chunk;
    logic [DATA_W-1:0] new_draw;
    logic [CNT_W-1:0]  new_bits;
    logic              draw_done;
    logic [REM_W-1:0]  rem_left;

    // One chunk step: take min(need, avail) bits from the word bottom
    always_comb
    begin
        stale     = (pbits_reg >= cfg_info.k);
        eff_bits  = stale ? '0 : pbits_reg;
        eff_draw  = stale ? '0 : pdraw_reg;
        need      = cfg_info.k - eff_bits;
        avail     = CNT_W'(rem_reg);
        take      = (need < avail) ? need : avail;
        chunk     = word_reg & ~({DATA_W{1'b1}} << take);
        new_draw  = eff_draw | (chunk << eff_bits);
        new_bits  = eff_bits + take;
        draw_done = (new_bits == cfg_info.k);
        rem_left  = rem_reg - REM_W'(take);
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        word_next  = word_reg;
        rem_next   = rem_reg;
        pdraw_next = pdraw_reg;
        pbits_next = pbits_reg;
        tok_next   = tok_reg;
        pop        = 1'b0;
        if (adv)
        begin
            tok_next.kind = TK_NONE;
            case (state_reg)
                ST_IDLE:
                begin
                    if (!q_empty)
                    begin
                        pop = 1'b1;
                        case (q_data.cls)
                            CLS_ERR:   tok_next.kind = TK_ERR;
                            CLS_EMPTY: tok_next.kind = TK_EMPTY;
                            default:
                            begin
                                word_next  = q_data.word;
                                rem_next   = REM_W'(WORD_BITS);
                                state_next = ST_DRAW;
                            end
                        endcase
                    end
                end
                ST_DRAW:
                begin
                    word_next = word_reg >> take;
                    rem_next  = rem_left;
                    if (draw_done)
                    begin
                        tok_next.kind = TK_DRAW;
                        tok_next.cand = new_draw;
                        pdraw_next    = '0;
                        pbits_next    = '0;
                    end
                    else
                    begin
                        pdraw_next = new_draw;
                        pbits_next = new_bits;
                    end
                    if (rem_left == '0)
                    begin
                        state_next = ST_END;
                    end
                end
                ST_END:
                begin
                    tok_next.kind = TK_END;
                    state_next    = ST_IDLE;
                end
                default:
                begin
                    state_next = ST_IDLE;
                end
            endcase
        end
        // A bound write drops any half-built draw
        if (cfg_info.clear)
        begin
            pdraw_next = '0;
            pbits_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            rem_reg   <= '0;
            pdraw_reg <= '0;
            pbits_reg <= '0;
            tok_reg   <= '{kind: TK_NONE, cand: '0};
        end
        else
        begin
            state_reg <= state_next;
            rem_reg   <= rem_next;
            pdraw_reg <= pdraw_next;
            pbits_reg <= pbits_next;
            tok_reg   <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign token = tok_reg;

    a_draw_has_bits: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DRAW |-> rem_reg != '0)
        else $error("draw step with no bits left in word");

endmodule

>>> hdl/brs_out.sv
// Range check, offset add, last-of-word hold-back and output register.
module brs_out (
    input  logic                          clk,
    input  logic                          rst_n,
    input  brs_pkg::cfg_info_t            cfg_info,
    input  brs_pkg::token_t               token,
    output logic                          adv,
    output logic                          result_valid,
    input  logic                          result_stall,
    output logic [brs_pkg::DATA_W-1:0]    drawn_value,
    output logic                          bounds_error,
    output logic                          last_of_word
);

    import brs_pkg::*;

    logic              valid_reg;
    logic [DATA_W-1:0] value_reg;
    logic              err_reg;
    logic              last_reg;
    logic              hold_valid_reg, hold_valid_next;
    logic [DATA_W-1:0] hold_value_reg, hold_value_next;

    logic              in_span;
    logic [DATA_W-1:0] sum;
    logic              emit;
    logic [DATA_W-1:0] emit_val;
    logic              emit_err;
    logic              emit_last;

    // Pipeline moves when the output register is free or being drained
    assign adv = !valid_reg || !result_stall;

    assign in_span = (token.cand <= cfg_info.span);
    assign sum     = token.cand + cfg_info.lower;

    // The newest accepted value waits in hold until we know if it is last
    always_comb
    begin
        emit            = 1'b0;
        emit_val        = '0;
        emit_err        = 1'b0;
        emit_last       = 1'b0;
        hold_valid_next = hold_valid_reg;
        hold_value_next = hold_value_reg;
        case (token.kind)
            TK_DRAW:
            begin
                if (in_span)
                begin
                    if (hold_valid_reg)
                    begin
                        emit     = 1'b1;
                        emit_val = hold_value_reg;
                    end
                    hold_valid_next = 1'b1;
                    hold_value_next = sum;
                end
            end
            TK_END:
            begin
                if (hold_valid_reg)
                begin
                    emit            = 1'b1;
                    emit_val        = hold_value_reg;
                    emit_last       = 1'b1;
                    hold_valid_next = 1'b0;
                end
            end
            TK_ERR:
            begin
                emit      = 1'b1;
                emit_err  = 1'b1;
                emit_last = 1'b1;
            end
            TK_EMPTY:
            begin
                emit      = 1'b1;
                emit_val  = cfg_info.lower;
                emit_last = 1'b1;
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= 1'b0;
            hold_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg      <= emit;
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            hold_value_reg <= hold_value_next;
            if (emit)
            begin
                value_reg <= emit_val;
                err_reg   <= emit_err;
                last_reg  <= emit_last;
            end
        end
    end

    assign result_valid = valid_reg;
    assign drawn_value  = value_reg;
    assign bounds_error = err_reg;
    assign last_of_word = last_reg;

    a_not_last_has_hold: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !last_reg |-> hold_valid_reg)
        else $error("non-final word shown with nothing held back");

    a_error_shape: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && err_reg |-> last_reg && value_reg == '0 && !hold_valid_reg)
        else $error("bounds error word malformed");

endmodule

>>> hdl/bounded_random_rejection_sampler.sv
// Top level of the bounded random rejection sampler.
//
// Usage: write lower_bound (index 0) and upper_bound (index 1) on the cfg
// port while the block is idle; each write also drops any half-built draw.
// Feed 64-bit entropy words on the entropy channel (valid/stall); only the
// low WORD_BITS bits are used. Each word yields zero or more result words
// on the result channel, uniform in [lower_bound, upper_bound], with
// last_of_word set on the final one. Reversed bounds give one result per
// word with bounds_error set; equal bounds give one result of lower_bound.
// A special-case word passes the queue, the token register and the output
// register; a normal word is loaded from the queue and cut into draws, and
// each accepted draw waits in a hold register before the output register,
// since the newest value is held until the next accepted draw or the end of
// the word shows it is last. The draw engine loads a word, runs its chunk
// steps (about WORD_BITS/k steps, k = bit width of upper-lower) and then
// closes the word before it takes the next; special-case words end at load.
// A queue of QUEUE_DEPTH words keeps the input open while the engine works.
// Reset clears both bounds to 0, the partial draw, the queue and the output.
// A stalled result holds its word and freezes the draw engine; the queue
// then fills and raises entropy_stall.
module bounded_random_rejection_sampler #(
    parameter int WORD_BITS   = 64,
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [brs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [brs_pkg::DATA_W-1:0]        cfg_data,
    input  logic                              entropy_valid,
    output logic                              entropy_stall,
    input  logic [brs_pkg::DATA_W-1:0]        entropy_word,
    output logic                              result_valid,
    input  logic                              result_stall,
    output logic [brs_pkg::DATA_W-1:0]        drawn_value,
    output logic                              bounds_error,
    output logic                              last_of_word
);

    import brs_pkg::*;

    cfg_info_t cfg_info;
    q_entry_t  q_in;
    q_entry_t  q_out;
    logic      push;
    logic      pop;
    logic      q_full;
    logic      q_empty;
    logic      adv;
    token_t    token;

    brs_front #(
        .WORD_BITS (WORD_BITS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .entropy_valid (entropy_valid),
        .entropy_stall (entropy_stall),
        .entropy_word  (entropy_word),
        .q_full        (q_full),
        .push          (push),
        .push_data     (q_in),
        .cfg_info      (cfg_info)
    );

    brs_fifo #(
        .WIDTH (DATA_W + $bits(word_class_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (pop),
        .pop_data  (q_out),
        .empty     (q_empty)
    );

    brs_back #(
        .WORD_BITS (WORD_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_info (cfg_info),
        .q_empty  (q_empty),
        .q_data   (q_out),
        .pop      (pop),
        .adv      (adv),
        .token    (token)
    );

    brs_out u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_info     (cfg_info),
        .token        (token),
        .adv          (adv),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .drawn_value  (drawn_value),
        .bounds_error (bounds_error),
        .last_of_word (last_of_word)
    );

endmodule

>>> test/bounded_random_rejection_sampler_tb.sv
// Self-checking testbench for the bounded random rejection sampler.
module bounded_random_rejection_sampler_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import brs_pkg::*;

    localparam int WORD_BITS   = 64;
    localparam int HOLD_CYCLES = 400;      // long receiver hold-off
    localparam int QUIET_WAIT  = 300;      // engine drain for words with no result
    localparam int LIMIT       = 1000000;  // cycle budget for the whole run

    localparam logic [DATA_W-1:0] ALL_ONES = '1;

    // Indexes past the last register; writes there must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    typedef struct packed
    {
        logic [DATA_W-1:0] value;
        logic              err;
        logic              last;
    } draw_t;

    typedef enum logic
    {
        ROW_CFG,
        ROW_WORD
    } row_kind_t;

    typedef struct packed
    {
        row_kind_t              kind;
        logic [CFG_IDX_W-1:0]   idx;
        logic [DATA_W-1:0]      data;
        logic                   typed;
        logic [DATA_W-1:0]      exp_value;
        logic                   exp_err;
    } stim_row_t;

    localparam int NROWS = 30;

    // Directed stimulus; typed rows give the single expected word directly
    localparam stim_row_t DIRECTED [NROWS] = '{
        // bounds after reset are equal: one word of lower_bound
        '{ROW_WORD, REG_LOWER,   64'h0123_4567_89AB_CDEF, 1'b1, 64'd0,    1'b0},
        // reversed bounds
        '{ROW_CFG,  REG_LOWER,   64'd100,                 1'b0, 64'd0,    1'b0},
        '{ROW_WORD, REG_LOWER,   64'd0,                   1'b1, 64'd0,    1'b1},
        '{ROW_WORD, REG_LOWER,   ALL_ONES,                1'b1, 64'd0,    1'b1},
        // empty range
        '{ROW_CFG,  REG_UPPER,   64'd100,                 1'b0, 64'd0,    1'b0},
        '{ROW_WORD, REG_LOWER,   64'h5A5A_5A5A_5A5A_5A5A, 1'b1, 64'd100,  1'b0},
        // full 64-bit range, one draw per word
        '{ROW_CFG,  REG_LOWER,   64'd0,                   1'b0, 64'd0,    1'b0},
        '{ROW_CFG,  REG_UPPER,   ALL_ONES,                1'b0, 64'd0,    1'b0},
        '{ROW_WORD, REG_LOWER,   64'd0,                   1'b1, 64'd0,    1'b0},
        '{ROW_WORD, REG_LOWER,   ALL_ONES,                1'b1, ALL_ONES, 1'b0},
        // one-bit draws: 64 results from one word
        '{ROW_CFG,  REG_UPPER,   64'd1,                   1'b0, 64'd0,    1'b0},
        '{ROW_WORD, REG_LOWER,   64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 64'd0,    1'b0},
        // range 4: all-ones word rejects every draw, leaves one bit behind
        '{ROW_CFG,  REG_UPPER,   64'd4,                   1'b0, 64'd0,    1'b0},
        '{ROW_WORD, REG_LOWER,   ALL_ONES,                1'b0, 64'd0,    1'b0},
        // spare indexes must keep that leftover bit
        '{ROW_CFG,  REG_SPARE_A, ALL_ONES,                1'b0, 64'd0,    1'b0},
        '{ROW_CFG,  REG_SPARE_B, 64'h1234,                1'b0, 64'd0,    1'b0},
        '{ROW_WORD, REG_LOWER,   64'd0,                   1'b0, 64'd0,    1'b0},
        '{ROW_WORD, REG_LOWER,   64'h9249_2492_4924_9249, 1'b0, 64'd0,    1'b0},
        // rewriting the same value still drops the partial draw
        '{ROW_CFG,  REG_UPPER,   64'd4,                   1'b0, 64'd0,    1'b0},
        '{ROW_WORD, REG_LOWER,   64'h0F0F_0F0F_0F0F_0F0F, 1'b0, 64'd0,    1'b0},
        // range 1 at the top of the value space
        '{ROW_CFG,  REG_LOWER,   64'hFFFF_FFFF_FFFF_FFFE, 1'b0, 64'd0,    1'b0},
        '{ROW_CFG,  REG_UPPER,   ALL_ONES,                1'b0, 64'd0,    1'b0},
        '{ROW_WORD, REG_LOWER,   64'h6666_0000_FFFF_1234, 1'b0, 64'd0,    1'b0},
        // empty range at the maximum
        '{ROW_CFG,  REG_LOWER,   ALL_ONES,                1'b0, 64'd0,    1'b0},
        '{ROW_WORD, REG_LOWER,   64'd0,                   1'b1, ALL_ONES, 1'b0},
        // 33-bit draws straddle word boundaries
        '{ROW_CFG,  REG_LOWER,   64'd0,                   1'b0, 64'd0,    1'b0},
        '{ROW_CFG,  REG_UPPER,   64'h1_0000_0005,         1'b0, 64'd0,    1'b0},
        '{ROW_WORD, REG_LOWER,   64'hDEAD_BEEF_0BAD_F00D, 1'b0, 64'd0,    1'b0},
        '{ROW_WORD, REG_LOWER,   64'h0000_0001_FFFF_FFFF, 1'b0, 64'd0,    1'b0},
        '{ROW_WORD, REG_LOWER,   64'h8000_0000_0000_0001, 1'b0, 64'd0,    1'b0}
    };

    logic                  clk;
    logic                  rst_n          = 1'b0;
    logic                  cfg_write      = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index      = REG_LOWER;
    logic [DATA_W-1:0]     cfg_data       = '0;
    logic                  entropy_valid  = 1'b0;
    logic                  entropy_stall;
    logic [DATA_W-1:0]     entropy_word   = '0;
    logic                  result_valid;
    logic                  result_stall   = 1'b0;
    logic [DATA_W-1:0]     drawn_value;
    logic                  bounds_error;
    logic                  last_of_word;

    // Model of the sampler's registers and carry-over draw
    logic [DATA_W-1:0]     lower_bd;
    logic [DATA_W-1:0]     upper_bd;
    logic [DATA_W-1:0]     carry_draw;
    int                    carry_bits;

    draw_t                 draws_due[$];     // results still to come, oldest first
    draw_t                 word_draws[$];    // results of the word just accepted

    int                    errors        = 0;
    int                    cycles        = 0;
    int                    send_idle_pct = 0;
    int                    recv_idle_pct = 0;
    int unsigned           hold_asks     = 0;
    bit                    words_in_flight = 0;

    bounded_random_rejection_sampler #(
        .WORD_BITS (WORD_BITS)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .entropy_valid (entropy_valid),
        .entropy_stall (entropy_stall),
        .entropy_word  (entropy_word),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .drawn_value   (drawn_value),
        .bounds_error  (bounds_error),
        .last_of_word  (last_of_word)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic logic [DATA_W-1:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic int span_width(input logic [DATA_W-1:0] span);
        int n;
        n = 0;
        while (span != 0)
        begin
            n++;
            span = span >> 1;
        end
        return n;
    endfunction

    // Cut one word into draws and fill word_draws with the accepted ones
    function automatic void cut_draws(input logic [DATA_W-1:0] w);
        logic [DATA_W-1:0] span;
        logic [DATA_W-1:0] chunk;
        logic [DATA_W-1:0] mask;
        int                k;
        int                pos;
        int                take;
        int                n;
        draw_t             d;
        word_draws = {};
        if (upper_bd < lower_bd)
        begin
            word_draws.push_back('{value: '0, err: 1'b1, last: 1'b1});
            return;
        end
        span = upper_bd - lower_bd;
        if (span == 0)
        begin
            word_draws.push_back('{value: lower_bd, err: 1'b0, last: 1'b1});
            return;
        end
        k = span_width(span);
        if (carry_bits >= k)
        begin
            carry_draw = '0;
            carry_bits = 0;
        end
        pos = 0;
        n   = 0;
        while (pos < WORD_BITS)
        begin
            take = k - carry_bits;
            if (take > WORD_BITS - pos)
                take = WORD_BITS - pos;
            mask  = (take >= DATA_W) ? ALL_ONES : ((64'd1 << take) - 64'd1);
            chunk = (w >> pos) & mask;
            carry_draw = carry_draw | (chunk << carry_bits);
            carry_bits += take;
            pos        += take;
            if (carry_bits >= k)
            begin
                if (carry_draw <= span && n < 64)
                begin
                    word_draws.push_back('{value: carry_draw + lower_bd, err: 1'b0,
                                           last: 1'b0});
                    n++;
                end
                carry_draw = '0;
                carry_bits = 0;
            end
        end
        if (n > 0)
        begin
            d = word_draws.pop_back();
            d.last = 1'b1;
            word_draws.push_back(d);
        end
    endfunction

    // Register write, then cfg_write low before returning; call at a falling edge
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_write <= 1'b0;
        case (idx)
            REG_LOWER:
            begin
                lower_bd   = val;
                carry_draw = '0;
                carry_bits = 0;
            end
            REG_UPPER:
            begin
                upper_bd   = val;
                carry_draw = '0;
                carry_bits = 0;
            end
            default: ;
        endcase
        @(negedge clk);
    endtask

    // Offer one entropy word; returns at the falling edge after acceptance
    task automatic send_word(input logic [DATA_W-1:0] w, input logic typed,
                             input draw_t typed_draw);
        while ($urandom_range(99) < send_idle_pct)
        begin
            entropy_valid <= 1'b0;
            @(negedge clk);
        end
        entropy_valid <= 1'b1;
        entropy_word  <= w;
        do
            @(posedge clk);
        while (entropy_stall);
        cut_draws(w);
        if (typed)
            word_draws = '{typed_draw};
        foreach (word_draws[i])
            draws_due.push_back(word_draws[i]);
        words_in_flight = 1;
        @(negedge clk);
    endtask

    // Stop offering words and let the block run dry; call at a falling edge
    task automatic wait_quiet();
        entropy_valid <= 1'b0;
        while (draws_due.size() != 0)
            @(negedge clk);
        if (words_in_flight)
            repeat (QUIET_WAIT) @(negedge clk);
        words_in_flight = 0;
    endtask

    // Random bounds: mostly narrow ranges, some wide, reversed and empty
    task automatic pick_bounds(output logic [DATA_W-1:0] lo, output logic [DATA_W-1:0] hi);
        logic [DATA_W-1:0] span;
        int                sel;
        int                w;
        sel = $urandom_range(9);
        lo  = rand64() >> $urandom_range(63);
        if (sel == 0)
        begin
            lo = rand64();
            hi = rand64();
            if (hi > lo)
                {lo, hi} = {hi, lo};
            if (hi == lo)
            begin
                if (lo == 0)
                    lo = 64'd1;
                else
                    hi = lo - 64'd1;
            end
        end
        else if (sel == 1)
            hi = lo;
        else
        begin
            if (sel <= 6)
                w = $urandom_range(1, 8);
            else if (sel <= 8)
                w = $urandom_range(9, 64);
            else
                w = 64;
            span = (rand64() >> (64 - w)) | (64'd1 << (w - 1));
            if (lo > ~span)
                lo = ~span;
            hi = lo + span;
        end
    endtask

    // Receiver: random stall, or a long hold-off when one is asked for
    initial
    begin : receiver
        int          hold_left;
        int unsigned hold_seen;
        hold_left = 0;
        hold_seen = 0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                result_stall <= 1'b1;
                hold_left--;
            end
            else if (hold_asks != hold_seen)
            begin
                hold_seen    = hold_asks;
                hold_left    = HOLD_CYCLES - 1;
                result_stall <= 1'b1;
            end
            else
                result_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Compare each accepted result word with the oldest expectation
    always @(posedge clk)
    begin : check_results
        draw_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (draws_due.size() == 0)
            begin
                $display("%0t: unexpected result: value %h error %b last %b",
                         $time, drawn_value, bounds_error, last_of_word);
                errors++;
            end
            else
            begin
                want = draws_due.pop_front();
                if (drawn_value !== want.value)
                begin
                    $display("%0t: drawn_value expected %h, got %h",
                             $time, want.value, drawn_value);
                    errors++;
                end
                if (bounds_error !== want.err)
                begin
                    $display("%0t: bounds_error expected %b, got %b",
                             $time, want.err, bounds_error);
                    errors++;
                end
                if (last_of_word !== want.last)
                begin
                    $display("%0t: last_of_word expected %b, got %b",
                             $time, want.last, last_of_word);
                    errors++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("%0t: timeout, %0d results still expected", $time, draws_due.size());
            $display("bounded_random_rejection_sampler_tb: done, errors");
            $finish;
        end
    end

    // Main sequence
    initial
    begin : stimulus
        logic [DATA_W-1:0] lo;
        logic [DATA_W-1:0] hi;
        draw_t             typed_draw;
        lower_bd   = '0;
        upper_bd   = '0;
        carry_draw = '0;
        carry_bits = 0;

        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed rows, no idling
        foreach (DIRECTED[r])
        begin
            if (DIRECTED[r].kind == ROW_CFG)
            begin
                wait_quiet();
                write_reg(DIRECTED[r].idx, DIRECTED[r].data);
            end
            else
            begin
                typed_draw = '{value: DIRECTED[r].exp_value, err: DIRECTED[r].exp_err,
                               last: 1'b1};
                send_word(DIRECTED[r].data, DIRECTED[r].typed, typed_draw);
            end
        end

        // Random words in three idling phases, new bounds every 12 words
        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 14;
                    recv_idle_pct = 66;
                end
                1:
                begin
                    send_idle_pct = 66;
                    recv_idle_pct = 14;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (int set = 0; set < 4; set++)
            begin
                wait_quiet();
                pick_bounds(lo, hi);
                write_reg(REG_LOWER, lo);
                write_reg(REG_UPPER, hi);
                if ($urandom_range(3) == 0)
                    write_reg($urandom_range(1) ? REG_SPARE_A : REG_SPARE_B, rand64());
                // back-pressure: receiver holds off while words keep coming
                if (phase == 0 && set == 0)
                    hold_asks++;
                repeat (12) send_word(rand64(), 1'b0, '0);
            end
        end

        wait_quiet();
        if (errors == 0)
            $display("bounded_random_rejection_sampler_tb: done, clean");
        else
            $display("bounded_random_rejection_sampler_tb: done, errors");
        $finish;
    end

endmodule
